>>> rtl/core/shj_pkg.sv
// ----------------------------------------------------------------------------
// shj_pkg
// Shared types, constants and the coil step pattern for the two-axis
// stepper homing and jog controller.
// ----------------------------------------------------------------------------
package shj_pkg;

  localparam int MAX_TRAVEL = 4095;
  localparam int PHASES     = 4;
  localparam int PH_W       = $clog2(PHASES);
  localparam int CNT_W      = $clog2(MAX_TRAVEL + 1) + 1;
  localparam int COIL_W     = 4;
  localparam int MODE_W     = 4;

  // Clockwise drive order; counter-clockwise is the same order reversed.
  localparam logic [COIL_W-1:0] PAT_CW [PHASES] = '{4'b0001, 4'b0100, 4'b0010, 4'b1000};

  typedef enum logic [MODE_W-1:0] {
    MODE_XY_SEARCH_RIGHT = 4'd0,
    MODE_XY_RETURN_LEFT  = 4'd1,
    MODE_XY_SEARCH_LEFT  = 4'd2,
    MODE_XY_RETURN_RIGHT = 4'd3,
    MODE_Z_SEARCH_DOWN   = 4'd4,
    MODE_Z_RETURN_UP     = 4'd5,
    MODE_Z_SEARCH_UP     = 4'd6,
    MODE_Z_RETURN_DOWN   = 4'd7,
    MODE_RUN             = 4'd8
  } mode_t;

  // Everything the beat emitter needs to replay one tick.
  typedef struct packed {
    mode_t             mode;
    logic [COIL_W-1:0] coil_xy;
    logic [COIL_W-1:0] coil_z;
    logic [COIL_W-1:0] coil_xy_mid;
    logic              xy_go;
    logic              xy_cw;
    logic              z_go;
    logic              z_cw;
  } shj_plan_t;

  function automatic logic [COIL_W-1:0] step_pattern(input logic cw,
                                                     input logic [PH_W-1:0] ph);
    logic [PH_W-1:0] k;
    k = cw ? ph : PH_W'(PHASES - 1) - ph;
    return PAT_CW[k];
  endfunction

endpackage

>>> rtl/core/shj_tick_if.sv
// ----------------------------------------------------------------------------
// shj_tick_if
// Input channel: one control tick with jog buttons and limit switches.
// ----------------------------------------------------------------------------
interface shj_tick_if;
  logic valid;
  logic ready;
  logic command;
  logic btn_right;
  logic btn_left;
  logic btn_up;
  logic btn_down;
  logic switch_right;
  logic switch_left;
  logic switch_down;
  logic switch_up;

  modport source (
    output valid, command, btn_right, btn_left, btn_up, btn_down,
           switch_right, switch_left, switch_down, switch_up,
    input  ready
  );
  modport sink (
    input  valid, command, btn_right, btn_left, btn_up, btn_down,
           switch_right, switch_left, switch_down, switch_up,
    output ready
  );
endinterface

>>> rtl/core/shj_drive_if.sv
// ----------------------------------------------------------------------------
// shj_drive_if
// Output channel: one coil drive pattern beat per handshake.
// ----------------------------------------------------------------------------
interface shj_drive_if;
  import shj_pkg::*;
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_xy;
  logic [COIL_W-1:0] coil_z;
  logic [MODE_W-1:0] mode;
  logic              last;

  modport source (output valid, coil_xy, coil_z, mode, last, input ready);
  modport sink (input valid, coil_xy, coil_z, mode, last, output ready);
endinterface

>>> rtl/core/shj_ctrl.sv
// ----------------------------------------------------------------------------
// shj_ctrl
// Homing sequencer and jog decision. Updates axis state once per tick and
// hands a step plan to the beat emitter.
// ----------------------------------------------------------------------------
module shj_ctrl
  import shj_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  shj_tick_if.sink      tick,
  output logic          plan_valid,
  output shj_plan_t     plan,
  input  logic          plan_take
);

  localparam logic signed [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_TRAVEL);
  localparam logic signed [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  mode_t                    mode_reg, mode_reg_next;
  logic signed [CNT_W-1:0]  pos_xy, pos_xy_next;
  logic signed [CNT_W-1:0]  pos_z, pos_z_next;
  logic signed [CNT_W-1:0]  limit_right, limit_right_next;
  logic signed [CNT_W-1:0]  limit_left, limit_left_next;
  logic signed [CNT_W-1:0]  limit_down, limit_down_next;
  logic signed [CNT_W-1:0]  limit_up, limit_up_next;
  logic signed [CNT_W-1:0]  return_count, return_count_next;
  logic [COIL_W-1:0]        coil_xy_reg, coil_z_reg;
  shj_plan_t                plan_next;
  logic                     xy_go, xy_cw, z_go, z_cw;
  logic                     conflict, accept;

  assign tick.ready = !plan_valid || plan_take;
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    mode_reg_next     = mode_reg;
    pos_xy_next       = pos_xy;
    pos_z_next        = pos_z;
    limit_right_next  = limit_right;
    limit_left_next   = limit_left;
    limit_down_next   = limit_down;
    limit_up_next     = limit_up;
    return_count_next = return_count;
    xy_go             = 1'b0;
    xy_cw             = 1'b0;
    z_go              = 1'b0;
    z_cw              = 1'b0;
    conflict          = (tick.btn_right && tick.btn_left) || (tick.btn_up && tick.btn_down);

    if (tick.command) begin
      mode_reg_next     = MODE_XY_SEARCH_RIGHT;
      pos_xy_next       = CNT_ZERO;
      pos_z_next        = CNT_ZERO;
      limit_right_next  = CNT_ZERO;
      limit_left_next   = CNT_ZERO;
      limit_down_next   = CNT_ZERO;
      limit_up_next     = CNT_ZERO;
      return_count_next = CNT_ZERO;
    end else begin
      unique case (mode_reg)
        MODE_XY_SEARCH_RIGHT: begin
          if (tick.switch_right || limit_right >= MAX_CNT) begin
            return_count_next = limit_right;
            mode_reg_next     = MODE_XY_RETURN_LEFT;
          end else begin
            xy_go            = 1'b1;
            xy_cw            = 1'b1;
            limit_right_next = limit_right + CNT_ONE;
          end
        end
        MODE_XY_SEARCH_LEFT: begin
          if (tick.switch_left || limit_left <= -MAX_CNT) begin
            return_count_next = -limit_left;
            mode_reg_next     = MODE_XY_RETURN_RIGHT;
          end else begin
            xy_go           = 1'b1;
            limit_left_next = limit_left - CNT_ONE;
          end
        end
        MODE_Z_SEARCH_DOWN: begin
          if (tick.switch_down || limit_down >= MAX_CNT) begin
            return_count_next = limit_down;
            mode_reg_next     = MODE_Z_RETURN_UP;
          end else begin
            z_go            = 1'b1;
            z_cw            = 1'b1;
            limit_down_next = limit_down + CNT_ONE;
          end
        end
        MODE_Z_SEARCH_UP: begin
          if (tick.switch_up || limit_up <= -MAX_CNT) begin
            return_count_next = -limit_up;
            mode_reg_next     = MODE_Z_RETURN_DOWN;
          end else begin
            z_go          = 1'b1;
            limit_up_next = limit_up - CNT_ONE;
          end
        end
        MODE_XY_RETURN_LEFT, MODE_XY_RETURN_RIGHT,
        MODE_Z_RETURN_UP, MODE_Z_RETURN_DOWN: begin
          if (return_count <= CNT_ZERO) begin
            return_count_next = CNT_ZERO;
            if (mode_reg == MODE_XY_RETURN_RIGHT) begin
              pos_xy_next = CNT_ZERO;
            end
            if (mode_reg == MODE_Z_RETURN_DOWN) begin
              pos_z_next = CNT_ZERO;
            end
            mode_reg_next = mode_t'(mode_reg + MODE_W'(1));
          end else begin
            // Return phases of the Z axis start at the Z up return.
            if (mode_reg == MODE_Z_RETURN_UP || mode_reg == MODE_Z_RETURN_DOWN) begin
              z_go = 1'b1;
              z_cw = (mode_reg == MODE_Z_RETURN_DOWN);
            end else begin
              xy_go = 1'b1;
              xy_cw = (mode_reg == MODE_XY_RETURN_RIGHT);
            end
            return_count_next = return_count - CNT_ONE;
          end
        end
        default: begin
          if (!conflict) begin
            if (tick.btn_right && pos_xy < limit_right) begin
              xy_go       = 1'b1;
              xy_cw       = 1'b1;
              pos_xy_next = pos_xy + CNT_ONE;
            end else if (tick.btn_left && pos_xy > limit_left) begin
              xy_go       = 1'b1;
              pos_xy_next = pos_xy - CNT_ONE;
            end
            if (tick.btn_down && pos_z < limit_down) begin
              z_go       = 1'b1;
              z_cw       = 1'b1;
              pos_z_next = pos_z + CNT_ONE;
            end else if (tick.btn_up && pos_z > limit_up) begin
              z_go       = 1'b1;
              pos_z_next = pos_z - CNT_ONE;
            end
          end
          mode_reg_next = MODE_RUN;
        end
      endcase
    end

    plan_next.xy_go       = xy_go;
    plan_next.xy_cw       = xy_cw;
    plan_next.z_go        = z_go;
    plan_next.z_cw        = z_cw;
    plan_next.coil_xy     = coil_xy_reg;
    plan_next.coil_z      = coil_z_reg;
    plan_next.coil_xy_mid = xy_go ? step_pattern(xy_cw, PH_W'(PHASES - 1)) : coil_xy_reg;
    // Step beats report the mode during the tick, an idle beat the mode after it.
    plan_next.mode        = (xy_go || z_go) ? mode_reg : mode_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_XY_SEARCH_RIGHT;
      pos_xy       <= '0;
      pos_z        <= '0;
      limit_right  <= '0;
      limit_left   <= '0;
      limit_down   <= '0;
      limit_up     <= '0;
      return_count <= '0;
      coil_xy_reg  <= '0;
      coil_z_reg   <= '0;
      plan_valid   <= 1'b0;
    end else if (accept) begin
      mode_reg     <= mode_reg_next;
      pos_xy       <= pos_xy_next;
      pos_z        <= pos_z_next;
      limit_right  <= limit_right_next;
      limit_left   <= limit_left_next;
      limit_down   <= limit_down_next;
      limit_up     <= limit_up_next;
      return_count <= return_count_next;
      coil_xy_reg  <= plan_next.coil_xy_mid;
      coil_z_reg   <= z_go ? step_pattern(z_cw, PH_W'(PHASES - 1)) : coil_z_reg;
      plan_valid   <= 1'b1;
    end else if (plan_take) begin
      plan_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

`ifndef SYNTHESIS
  // Jogging never leaves the learned travel window.
  a_run_in_window: assert property (@(posedge clk) disable iff (rst)
    mode_reg == MODE_RUN |-> (pos_xy <= limit_right && pos_xy >= limit_left &&
                              pos_z <= limit_down && pos_z >= limit_up))
    else $error("shj_ctrl: position outside learned limits");

  a_return_nonneg: assert property (@(posedge clk) disable iff (rst)
    !return_count[CNT_W-1])
    else $error("shj_ctrl: return count went negative");

  a_plan_held: assert property (@(posedge clk) disable iff (rst)
    plan_valid && !plan_take |=> plan_valid && $stable(plan))
    else $error("shj_ctrl: waiting plan changed before it was taken");
`endif

endmodule

>>> rtl/core/shj_emit.sv
// ----------------------------------------------------------------------------
// shj_emit
// Beat emitter: replays one step plan as one, four or eight coil beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module shj_emit
  import shj_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          plan_valid,
  input  shj_plan_t     plan,
  output logic          plan_take,
  shj_drive_if.source   drive
);

  logic              busy;
  shj_plan_t         cur;
  logic [PH_W:0]     idx;
  logic [PH_W-1:0]   ph;
  logic              idle, seg_z, advance, beat_last;
  logic [COIL_W-1:0] beat_xy, beat_z;

  assign ph      = idx[PH_W-1:0];
  assign idle    = !cur.xy_go && !cur.z_go;
  // The XY steps come first; Z beats follow in the upper half when both move.
  assign seg_z   = cur.z_go && (!cur.xy_go || idx[PH_W]);
  assign beat_xy = idle ? cur.coil_xy :
                   seg_z ? cur.coil_xy_mid : step_pattern(cur.xy_cw, ph);
  assign beat_z  = seg_z ? step_pattern(cur.z_cw, ph) : cur.coil_z;
  assign beat_last = idle ||
                     (ph == PH_W'(PHASES - 1) && (!(cur.xy_go && cur.z_go) || idx[PH_W]));

  assign advance   = busy && (!drive.valid || drive.ready);
  assign plan_take = !busy || (advance && beat_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      drive.valid <= 1'b0;
      idx         <= '0;
    end else begin
      if (plan_take) begin
        busy <= plan_valid;
        idx  <= '0;
      end else if (advance) begin
        idx  <= idx + (PH_W + 1)'(1);
      end
      if (advance) begin
        drive.valid <= 1'b1;
      end else if (drive.ready) begin
        drive.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_take && plan_valid) begin
      cur <= plan;
    end
    if (advance) begin
      drive.coil_xy <= beat_xy;
      drive.coil_z  <= beat_z;
      drive.mode    <= cur.mode;
      drive.last    <= beat_last;
    end
  end

`ifndef SYNTHESIS
  a_plan_loaded: assert property (@(posedge clk) disable iff (rst)
    plan_take && plan_valid |=> busy)
    else $error("shj_emit: plan taken but emitter not busy");

  a_upper_half: assert property (@(posedge clk) disable iff (rst)
    busy && idx[PH_W] |-> (cur.xy_go && cur.z_go))
    else $error("shj_emit: second step segment without two axes moving");

  a_coil_onehot: assert property (@(posedge clk) disable iff (rst)
    drive.valid |-> ($onehot0(drive.coil_xy) && $onehot0(drive.coil_z)))
    else $error("shj_emit: coil pattern drives more than one coil");
`endif

endmodule

>>> rtl/core/two_axis_stepper_homing_jog.sv
// An accepted tick's plan is registered in the controller, loaded into the emitter's plan
// register and then sent through the output register. Beats leave at one per cycle while
// the receiver is ready; a tick yields one, four or eight beats, one plan at a time.
// A new tick is taken while the previous one is still being emitted.
// Reset (rst, synchronous) enters the XY right search with counts, limits and coils zero.
// ----------------------------------------------------------------------------
// two_axis_stepper_homing_jog
// Two-axis stepper controller: homes XY then Z against their end switches,
// then jogs both axes inside the learned limits from the jog buttons.
// ----------------------------------------------------------------------------
module two_axis_stepper_homing_jog
  import shj_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  shj_tick_if.sink    tick,
  shj_drive_if.source drive
);

  logic      plan_valid;
  logic      plan_take;
  shj_plan_t plan;

  shj_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take)
  );

  shj_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (plan_valid),
    .plan       (plan),
    .plan_take  (plan_take),
    .drive      (drive)
  );

endmodule

>>> tb/two_axis_stepper_homing_jog_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_stepper_homing_jog_checker
// Watches the tick and drive channels, predicts the coil beats of every
// accepted tick from its own copy of the homing and jog state, and compares
// each beat leaving the block against the oldest prediction.
// ----------------------------------------------------------------------------
module two_axis_stepper_homing_jog_checker
  import shj_pkg::*;
(
  input  logic clk,
  input  logic rst,
  shj_tick_if  tick,
  shj_drive_if drive,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [COIL_W-1:0] coil_xy;
    logic [COIL_W-1:0] coil_z;
    logic [MODE_W-1:0] mode;
    logic              last;
  } beat_t;

  beat_t coil_q[$];
  beat_t tick_beats[8];
  int    tick_n;

  mode_t                   run_mode;
  logic signed [CNT_W-1:0] xy_pos;
  logic signed [CNT_W-1:0] z_pos;
  logic signed [CNT_W-1:0] right_lim;
  logic signed [CNT_W-1:0] left_lim;
  logic signed [CNT_W-1:0] down_lim;
  logic signed [CNT_W-1:0] up_lim;
  logic signed [CNT_W-1:0] back_count;
  logic [COIL_W-1:0]       xy_coil;
  logic [COIL_W-1:0]       z_coil;

  // Clockwise drives 1,4,2,8; counter-clockwise drives the same coils backward.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic cw, input int ph);
    int k;
    k = cw ? ph : PHASES - 1 - ph;
    case (k)
      0: return 4'b0001;
      1: return 4'b0100;
      2: return 4'b0010;
      default: return 4'b1000;
    endcase
  endfunction

  task automatic add_step(input logic z_axis, input logic cw);
    for (int ph = 0; ph < PHASES; ph++) begin
      if (z_axis) begin
        z_coil = coil_pattern(cw, ph);
      end else begin
        xy_coil = coil_pattern(cw, ph);
      end
      tick_beats[tick_n] = '{xy_coil, z_coil, run_mode, 1'b0};
      tick_n++;
    end
  endtask

  task automatic clear_homing();
    run_mode   = MODE_XY_SEARCH_RIGHT;
    xy_pos     = '0;
    z_pos      = '0;
    right_lim  = '0;
    left_lim   = '0;
    down_lim   = '0;
    up_lim     = '0;
    back_count = '0;
  endtask

  task automatic predict_tick(input logic cmd, input logic br, input logic bl,
                              input logic bu, input logic bd, input logic sr,
                              input logic sl, input logic sd, input logic su);
    logic blocked;
    tick_n = 0;
    if (cmd) begin
      clear_homing();
    end else begin
      case (run_mode)
        MODE_XY_SEARCH_RIGHT: begin
          if (sr || right_lim >= MAX_TRAVEL) begin
            back_count = right_lim;
            run_mode   = MODE_XY_RETURN_LEFT;
          end else begin
            add_step(1'b0, 1'b1);
            right_lim++;
          end
        end
        MODE_XY_SEARCH_LEFT: begin
          if (sl || -left_lim >= MAX_TRAVEL) begin
            back_count = -left_lim;
            run_mode   = MODE_XY_RETURN_RIGHT;
          end else begin
            add_step(1'b0, 1'b0);
            left_lim--;
          end
        end
        MODE_Z_SEARCH_DOWN: begin
          if (sd || down_lim >= MAX_TRAVEL) begin
            back_count = down_lim;
            run_mode   = MODE_Z_RETURN_UP;
          end else begin
            add_step(1'b1, 1'b1);
            down_lim++;
          end
        end
        MODE_Z_SEARCH_UP: begin
          if (su || -up_lim >= MAX_TRAVEL) begin
            back_count = -up_lim;
            run_mode   = MODE_Z_RETURN_DOWN;
          end else begin
            add_step(1'b1, 1'b0);
            up_lim--;
          end
        end
        MODE_XY_RETURN_LEFT, MODE_XY_RETURN_RIGHT, MODE_Z_RETURN_UP, MODE_Z_RETURN_DOWN: begin
          if (back_count <= 0) begin
            back_count = '0;
            if (run_mode == MODE_XY_RETURN_RIGHT) xy_pos = '0;
            if (run_mode == MODE_Z_RETURN_DOWN) z_pos = '0;
            run_mode = mode_t'(run_mode + 1);
          end else begin
            add_step(run_mode == MODE_Z_RETURN_UP || run_mode == MODE_Z_RETURN_DOWN,
                     run_mode == MODE_XY_RETURN_RIGHT || run_mode == MODE_Z_RETURN_DOWN);
            back_count--;
          end
        end
        default: begin
          // Both buttons of either axis pressed freezes both axes.
          blocked = (br && bl) || (bu && bd);
          if (!blocked) begin
            if (br && xy_pos < right_lim) begin
              add_step(1'b0, 1'b1);
              xy_pos++;
            end else if (bl && xy_pos > left_lim) begin
              add_step(1'b0, 1'b0);
              xy_pos--;
            end
            if (bd && z_pos < down_lim) begin
              add_step(1'b1, 1'b1);
              z_pos++;
            end else if (bu && z_pos > up_lim) begin
              add_step(1'b1, 1'b0);
              z_pos--;
            end
          end
          run_mode = MODE_RUN;
        end
      endcase
    end
    if (tick_n == 0) begin
      tick_beats[0] = '{xy_coil, z_coil, run_mode, 1'b0};
      tick_n = 1;
    end
    tick_beats[tick_n-1].last = 1'b1;
    for (int i = 0; i < tick_n; i++) coil_q.push_back(tick_beats[i]);
  endtask

  task automatic check_beat();
    beat_t seen;
    beat_t want;
    seen = '{drive.coil_xy, drive.coil_z, drive.mode, drive.last};
    if (coil_q.size() == 0) begin
      if (errors < 10)
        $display("unexpected beat: xy=%h z=%h mode=%0d last=%b",
                 seen.coil_xy, seen.coil_z, seen.mode, seen.last);
      errors++;
    end else begin
      want = coil_q.pop_front();
      if (seen !== want) begin
        if (errors < 10)
          $display("expected xy=%h z=%h mode=%0d last=%b, got xy=%h z=%h mode=%0d last=%b",
                   want.coil_xy, want.coil_z, want.mode, want.last,
                   seen.coil_xy, seen.coil_z, seen.mode, seen.last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_homing();
      xy_coil = '0;
      z_coil  = '0;
      coil_q.delete();
    end else begin
      // A beat at this edge can only belong to a tick accepted earlier.
      if (drive.valid && drive.ready) check_beat();
      if (tick.valid && tick.ready)
        predict_tick(tick.command, tick.btn_right, tick.btn_left, tick.btn_up, tick.btn_down,
                     tick.switch_right, tick.switch_left, tick.switch_down, tick.switch_up);
    end
    pending = coil_q.size();
  end

endmodule

>>> tb/two_axis_stepper_homing_jog_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_stepper_homing_jog_tb
// Drives control ticks into the stepper controller: a directed walk through
// homing and jogging, then random ticks with occasional restarts. A checker
// alongside the block predicts and compares every coil beat.
// ----------------------------------------------------------------------------
module two_axis_stepper_homing_jog_tb;
  import shj_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_HOME = 1'b1;

  // Button nibble is {right, left, up, down}; switch nibble is {right, left, down, up}.
  localparam logic [3:0] BTN_R  = 4'b1000;
  localparam logic [3:0] BTN_L  = 4'b0100;
  localparam logic [3:0] BTN_U  = 4'b0010;
  localparam logic [3:0] BTN_D  = 4'b0001;
  localparam logic [3:0] SW_R   = 4'b1000;
  localparam logic [3:0] SW_L   = 4'b0100;
  localparam logic [3:0] SW_D   = 4'b0010;
  localparam logic [3:0] SW_U   = 4'b0001;
  localparam logic [3:0] NONE   = 4'b0000;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   cycle_count;
  int   burst_left;
  int unsigned stall_style;
  int unsigned stall_left;
  int unsigned stall_phase;

  shj_tick_if  tick();
  shj_drive_if drive();

  two_axis_stepper_homing_jog uut (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .drive (drive)
  );

  two_axis_stepper_homing_jog_checker chk (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .drive   (drive),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver switches between styles of back-pressure, holding each for a random span.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_style)
      0: drive.ready <= 1'b1;
      1: drive.ready <= (stall_phase % 4 != 3);
      2: drive.ready <= 1'($urandom_range(0, 1));
      default: drive.ready <= ($urandom_range(0, 5) == 0) ? !drive.ready : drive.ready;
    endcase
  end

  // Ends a tick burst now and then with a gap of idle cycles.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        tick.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_tick(input logic cmd, input logic [3:0] btn, input logic [3:0] sw);
    tick.valid   <= 1'b1;
    tick.command <= cmd;
    {tick.btn_right, tick.btn_left, tick.btn_up, tick.btn_down} <= btn;
    {tick.switch_right, tick.switch_left, tick.switch_down, tick.switch_up} <= sw;
    @(posedge clk);
    while (!tick.ready) @(posedge clk);
    @(negedge clk);
    pace();
  endtask

  task automatic wait_all_beats();
    tick.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_tick(input int restart_odds);
    logic [3:0] sw;
    logic       cmd;
    for (int b = 0; b < 4; b++) sw[b] = ($urandom_range(0, 2) == 0);
    cmd = ($urandom_range(1, restart_odds) == 1) ? CMD_HOME : CMD_TICK;
    send_tick(cmd, 4'($urandom_range(0, 15)), sw);
  endtask

  initial begin
    rst               = 1'b1;
    tick.valid        = 1'b0;
    tick.command      = CMD_TICK;
    tick.btn_right    = 1'b0;
    tick.btn_left     = 1'b0;
    tick.btn_up       = 1'b0;
    tick.btn_down     = 1'b0;
    tick.switch_right = 1'b0;
    tick.switch_left  = 1'b0;
    tick.switch_down  = 1'b0;
    tick.switch_up    = 1'b0;
    drive.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Homing with one-step searches right, left and down; buttons are ignored and only the phase's switch counts.
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, BTN_R | BTN_L | BTN_U | BTN_D, SW_R);
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, NONE, SW_R);
    send_tick(CMD_TICK, NONE, SW_L | SW_D | SW_U);
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, NONE, SW_U);
    send_tick(CMD_TICK, NONE, SW_D);
    send_tick(CMD_TICK, NONE, NONE);
    send_tick(CMD_TICK, NONE, NONE);
    // Up switch already closed: the return down has nothing to undo.
    send_tick(CMD_TICK, NONE, SW_U);
    send_tick(CMD_TICK, NONE, NONE);

    // Jogging inside limits of one step each way on XY, one step down on Z.
    send_tick(CMD_TICK, BTN_R, NONE);
    send_tick(CMD_TICK, BTN_R, NONE);
    send_tick(CMD_TICK, BTN_R | BTN_L | BTN_D, NONE);
    send_tick(CMD_TICK, BTN_U | BTN_D | BTN_L, NONE);
    send_tick(CMD_TICK, BTN_D | BTN_L, NONE);
    send_tick(CMD_TICK, BTN_D | BTN_R, NONE);
    send_tick(CMD_TICK, BTN_U | BTN_L, NONE);
    send_tick(CMD_TICK, BTN_L, NONE);
    send_tick(CMD_TICK, BTN_U, NONE);
    send_tick(CMD_TICK, BTN_R | BTN_L | BTN_U | BTN_D, SW_R | SW_L | SW_D | SW_U);
    send_tick(CMD_HOME, BTN_R | BTN_D, SW_R);
    send_tick(CMD_HOME, NONE, NONE);
    wait_all_beats();

    repeat (12) send_random_tick(1000);

    for (int k = 0; k < 300; k++) begin
      if (k == 150) wait_all_beats();
      send_random_tick(30);
    end

    wait_all_beats();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/shj_pkg.sv
rtl/core/shj_tick_if.sv
rtl/core/shj_drive_if.sv
rtl/core/shj_ctrl.sv
rtl/core/shj_emit.sv
rtl/core/two_axis_stepper_homing_jog.sv
tb/two_axis_stepper_homing_jog_checker.sv
tb/two_axis_stepper_homing_jog_tb.sv
